// ===== rtl/core/c_sl_pkg.sv =====
// ============================================================================
// c_sl_pkg
// Shared types, token codes and keyword tables for the C subset lexer.
// ============================================================================
package c_sl_pkg;

    // Input beat: one source byte or the end-of-text marker.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_beat;

    // Output beat: one token.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] tok_len;
        logic [31:0] num_value;
        logic [15:0] punct_code;
        logic [1:0]  keyword_id;
        logic        last_of_text;
    } t_out_beat;

    // Tokens produced by one input beat, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_beat  first;
        t_out_beat  second;
    } t_push;

    // Token kinds.
    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_KEYWORD = 3'd2;
    localparam logic [2:0] KIND_PUNCT   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Keyword identifiers.
    localparam logic [1:0] KW_ID_RETURN = 2'd0;
    localparam logic [1:0] KW_ID_IF     = 2'd1;
    localparam logic [1:0] KW_ID_ELSE   = 2'd2;

    // Keyword spellings, first character in the top byte.
    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [15:0] KW_IF     = "if";
    localparam logic [31:0] KW_ELSE   = "else";

    localparam logic [15:0] KW_LEN_RETURN = 16'd6;
    localparam logic [15:0] KW_LEN_IF     = 16'd2;
    localparam logic [15:0] KW_LEN_ELSE   = 16'd4;

    // Keeps only the keyword candidates whose character at idx equals c.
    function automatic logic [2:0] kw_filter(input logic [2:0]  mask,
                                             input logic [15:0] idx,
                                             input logic [7:0]  c);
        logic [2:0] res;
        logic [2:0] ret_sel;
        res     = 3'b000;
        ret_sel = 3'd5 - idx[2:0];
        if (mask[0] && idx < KW_LEN_RETURN && c == KW_RETURN[{ret_sel, 3'b000} +: 8]) begin
            res[0] = 1'b1;
        end
        if (mask[1] && idx < KW_LEN_IF && c == KW_IF[{~idx[0], 3'b000} +: 8]) begin
            res[1] = 1'b1;
        end
        if (mask[2] && idx < KW_LEN_ELSE && c == KW_ELSE[{~idx[1:0], 3'b000} +: 8]) begin
            res[2] = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/c_sl_core.sv =====
// ============================================================================
// c_sl_core
// Lexer state and per-byte token logic: consumes one beat per cycle while
// i_fire is high and reports up to two finished tokens for the output queue.
// ============================================================================
module c_sl_core #(
    parameter int MAX_TEXT = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  c_sl_pkg::t_in_beat i_beat,
    output c_sl_pkg::t_push   o_push
);
    import c_sl_pkg::*;

    localparam int PW = $clog2(MAX_TEXT);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_TEXT - 1);

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_NUM   = 5'b00010,
        MODE_IDENT = 5'b00100,
        MODE_HELD  = 5'b01000,
        MODE_ERR   = 5'b10000
    } t_lex_mode;

    t_lex_mode     r_mode,  n_mode;
    logic [PW-1:0] r_pos,   n_pos;
    logic [15:0]   r_start, n_start;
    logic [15:0]   r_len,   n_len;
    logic [63:0]   r_acc,   n_acc;
    logic [2:0]    r_kwm,   n_kwm;
    logic [7:0]    r_held,  n_held;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha_u(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    logic [7:0]  c;
    logic [15:0] pos16;
    logic [PW-1:0] pos_adv;
    logic [15:0] len_grow;
    logic [7:0]  digit;
    logic [67:0] acc_x10;
    logic        has_flush;
    t_out_beat   flush_res;
    logic        emit_a, emit_b;
    t_out_beat   res_a, res_b;
    logic        cont;

    assign c        = i_beat.ch;
    assign pos16    = 16'(r_pos);
    assign pos_adv  = (r_pos < POS_MAX) ? r_pos + PW'(1) : r_pos;
    assign len_grow = (r_len != 16'hFFFF) ? r_len + 16'd1 : r_len;
    assign digit    = c - "0";

    // Decimal accumulate with saturation at all ones.
    assign acc_x10 = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1) + {60'd0, digit};

    // Token that the pending state turns into when it ends.
    always_comb begin
        flush_res = '0;
        has_flush = 1'b0;
        unique case (r_mode)
            MODE_NUM: begin
                has_flush           = 1'b1;
                flush_res.kind      = KIND_NUMBER;
                flush_res.start_pos = r_start;
                flush_res.tok_len   = r_len;
                flush_res.num_value = r_acc[31:0];
            end
            MODE_IDENT: begin
                has_flush           = 1'b1;
                flush_res.kind      = KIND_IDENT;
                flush_res.start_pos = r_start;
                flush_res.tok_len   = r_len;
                priority if (r_kwm[2] && r_len == KW_LEN_ELSE) begin
                    flush_res.kind       = KIND_KEYWORD;
                    flush_res.keyword_id = KW_ID_ELSE;
                end else if (r_kwm[1] && r_len == KW_LEN_IF) begin
                    flush_res.kind       = KIND_KEYWORD;
                    flush_res.keyword_id = KW_ID_IF;
                end else if (r_kwm[0] && r_len == KW_LEN_RETURN) begin
                    flush_res.kind       = KIND_KEYWORD;
                    flush_res.keyword_id = KW_ID_RETURN;
                end else begin
                    flush_res.keyword_id = KW_ID_RETURN;
                end
            end
            MODE_HELD: begin
                has_flush            = 1'b1;
                flush_res.kind       = KIND_PUNCT;
                flush_res.start_pos  = r_start;
                flush_res.tok_len    = 16'd1;
                flush_res.punct_code = {8'h00, r_held};
            end
            default: begin
                has_flush = 1'b0;
            end
        endcase
    end

    // Per-beat next state and token generation.
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_acc   = r_acc;
        n_kwm   = r_kwm;
        n_held  = r_held;
        emit_a  = 1'b0;
        emit_b  = 1'b0;
        res_a   = flush_res;
        res_b   = '0;
        cont    = 1'b0;

        if (i_fire) begin
            if (i_beat.end_of_text) begin
                // End marker: flush, emit the end token, return to reset state.
                emit_a             = has_flush;
                emit_b             = 1'b1;
                res_b.kind         = KIND_END;
                res_b.start_pos    = pos16;
                res_b.last_of_text = 1'b1;
                n_mode  = MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_len   = '0;
                n_acc   = '0;
                n_kwm   = 3'b111;
                n_held  = '0;
            end else if (r_mode == MODE_ERR) begin
                n_pos = pos_adv;
            end else begin
                n_pos = pos_adv;
                if (r_mode == MODE_HELD && c == "=") begin
                    emit_b           = 1'b1;
                    res_b.kind       = KIND_PUNCT;
                    res_b.start_pos  = r_start;
                    res_b.tok_len    = 16'd2;
                    res_b.punct_code = {8'h3D, r_held};
                    n_mode           = MODE_IDLE;
                    cont             = 1'b1;
                end else if (r_mode == MODE_NUM && is_digit(c)) begin
                    n_acc = (acc_x10[67:64] != 4'd0) ? '1 : acc_x10[63:0];
                    n_len = len_grow;
                    cont  = 1'b1;
                end else if (r_mode == MODE_IDENT && (is_alpha_u(c) || is_digit(c))) begin
                    n_kwm = kw_filter(r_kwm, r_len, c);
                    n_len = len_grow;
                    cont  = 1'b1;
                end

                if (!cont) begin
                    // The pending token ends; the byte starts over from idle.
                    emit_a = has_flush;
                    n_mode = MODE_IDLE;
                    priority if (is_space(c)) begin
                        n_mode = MODE_IDLE;
                    end else if (is_digit(c)) begin
                        n_mode  = MODE_NUM;
                        n_start = pos16;
                        n_len   = 16'd1;
                        n_acc   = {56'd0, digit};
                    end else if (is_alpha_u(c)) begin
                        n_mode  = MODE_IDENT;
                        n_start = pos16;
                        n_len   = 16'd1;
                        n_kwm   = kw_filter(3'b111, 16'd0, c);
                    end else if (is_punct(c)) begin
                        if (c == "=" || c == "!" || c == "<" || c == ">") begin
                            n_mode  = MODE_HELD;
                            n_start = pos16;
                            n_held  = c;
                        end else begin
                            emit_b           = 1'b1;
                            res_b.kind       = KIND_PUNCT;
                            res_b.start_pos  = pos16;
                            res_b.tok_len    = 16'd1;
                            res_b.punct_code = {8'h00, c};
                        end
                    end else begin
                        emit_b          = 1'b1;
                        res_b.kind      = KIND_ERROR;
                        res_b.start_pos = pos16;
                        res_b.tok_len   = 16'd1;
                        n_mode          = MODE_ERR;
                    end
                end
            end
        end

        // Pack the tokens in order, the flushed one first.
        o_push.count  = {1'b0, emit_a} + {1'b0, emit_b};
        o_push.first  = emit_a ? res_a : res_b;
        o_push.second = res_b;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_kwm   <= 3'b111;
            r_held  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_kwm   <= n_kwm;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/core/c_sl_queue.sv =====
// ============================================================================
// c_sl_queue
// Four-entry token queue: takes up to two tokens per cycle, gives one
// beat per cycle unless stalled, stalls input if fewer than two are free.
// ============================================================================
module c_sl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c_sl_pkg::t_push     i_push,
    output logic                o_full,
    output logic                o_valid,
    output c_sl_pkg::t_out_beat o_data,
    input  logic                i_stall
);
    import c_sl_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_out_beat     r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          pop;
    logic [AW-1:0] wp_next;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt > (AW + 1)'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign wp_next = r_wp + AW'(1);

    // Pointer and occupancy update.
    always_comb begin
        n_wp  = r_wp + AW'(i_push.count);
        n_rp  = pop ? r_rp + AW'(1) : r_rp;
        n_cnt = r_cnt + (AW + 1)'(i_push.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Token storage, written at the tail and the slot after it.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

endmodule

// ===== rtl/core/c_subset_lexer.sv =====
// ============================================================================
// c_subset_lexer
// Streaming tokenizer for a small C subset: one source byte per beat in,
// tokens out in order with an end token after each text.
// ============================================================================
//  Channel | Direction | Handshake          | Beat
//  --------+-----------+--------------------+---------------------------
//  input   | in        | i_valid / o_stall  | t_in_beat  (byte or end)
//  output  | out       | o_valid / i_stall  | t_out_beat (one token)
//
// One input beat is taken per cycle while o_stall is low; its tokens enter
// the output queue at the edge that accepts it, so the first can leave in
// the next cycle, then one per cycle while i_stall is low. A beat yields at
// most two tokens, so input stalls if fewer than two of four slots are free.
// Reset is synchronous and clears the lexer state and the queue.
// Output stalls only back up the queue; no token is lost or repeated.
// ============================================================================
module c_subset_lexer #(
    parameter int MAX_TEXT = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  c_sl_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output c_sl_pkg::t_out_beat o_data
);
    import c_sl_pkg::*;

    t_push push;
    logic  full;
    logic  fire;

    assign o_stall = full;
    assign fire    = i_valid && !full;

    // Lexer state and token logic.
    c_sl_core #(
        .MAX_TEXT(MAX_TEXT)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_beat (i_data),
        .o_push (push)
    );

    // Output token queue.
    c_sl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

endmodule
